/* rtl/tovh_pkg.sv */
// Package for the per-sensor obstacle vote with hold.
// Holds sizes, register indexes, the per-sensor frame entry and the hold command.
// No dependencies.
`default_nettype none
package tovh_pkg;

   localparam int SENSORS    = 4;
   localparam int MAX_POINTS = 64;

   localparam int SENSOR_W = 2;
   localparam int RANGE_W  = 16;
   localparam int HOLD_W   = 16;
   localparam int PCT_W    = 7;
   localparam int COUNT_W  = $clog2(MAX_POINTS + 1);
   localparam int PROD_W   = COUNT_W + PCT_W;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);

   localparam logic [CSR_IDX_W-1:0] CSR_DISTANCE_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NEAR_PERCENT       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_TICKS         = 2'd2;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   typedef struct packed {
      logic               det;
      logic [COUNT_W-1:0] samples;
      logic [COUNT_W-1:0] nears;
   } entry_type;

   typedef struct packed {
      logic                tick;
      logic                load;
      logic                clear;
      logic [SENSOR_W-1:0] sensor;
      logic [HOLD_W-1:0]   value;
   } hold_cmd_type;

endpackage
`default_nettype wire

/* rtl/tovh_frame_mem.sv */
// Per-sensor frame memory: sample count, near count and obstacle flag.
// One synchronous read port and one write port; entries read as zero until written.
// Depends on tovh_pkg.
`default_nettype none
module tovh_frame_mem
   import tovh_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                rd_en,
   input  wire logic [SENSOR_W-1:0] rd_addr,
   output entry_type                rd_data,
   input  wire logic                wr_en,
   input  wire logic [SENSOR_W-1:0] wr_addr,
   input  wire entry_type           wr_data
);

   entry_type            mem [SENSORS];
   logic [SENSORS-1:0]   written_ff;
   logic [SENSORS-1:0]   written_in;
   entry_type            rdata_ff;
   logic                 rvalid_ff;

   always_comb begin
      written_in = written_ff;
      if (wr_en) begin
         written_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
         rvalid_ff  <= 1'b0;
      end else begin
         written_ff <= written_in;
         if (rd_en) begin
            rvalid_ff <= written_ff[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rvalid_ff ? rdata_ff : '0;

endmodule
`default_nettype wire

/* rtl/tovh_hold_bank.sv */
// Hold counters, one per sensor, that all count down together on a tick.
// Load, clear and tick commands arrive as one struct; the addressed counter is read out.
// Depends on tovh_pkg.
`default_nettype none
module tovh_hold_bank
   import tovh_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire hold_cmd_type        cmd,
   input  wire logic [SENSOR_W-1:0] sel,
   output logic [HOLD_W-1:0]        hold_left
);

   logic [HOLD_W-1:0] hold_ff [SENSORS];
   logic [HOLD_W-1:0] hold_in [SENSORS];

   always_comb begin
      for (int s = 0; s < SENSORS; s++) begin
         hold_in[s] = hold_ff[s];
         if (cmd.tick && hold_ff[s] != '0) begin
            hold_in[s] = hold_ff[s] - HOLD_W'(1);
         end else if (cmd.load && cmd.sensor == SENSOR_W'(s)) begin
            hold_in[s] = cmd.value;
         end else if (cmd.clear && cmd.sensor == SENSOR_W'(s)) begin
            hold_in[s] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SENSORS; s++) begin
            hold_ff[s] <= '0;
         end
      end else begin
         for (int s = 0; s < SENSORS; s++) begin
            hold_ff[s] <= hold_in[s];
         end
      end
   end

   assign hold_left = hold_ff[sel];

endmodule
`default_nettype wire

/* rtl/tof_obstacle_vote_with_hold.sv */
// Per-sensor obstacle vote with hold over time-of-flight frames.
// Input channel req_*: tuser carries op (bit 0), sensor (bits 2:1) and available (bit 3),
// tdata carries range_mm and tlast marks the last sample of a frame. An op of one is a
// 1 ms tick that counts every running hold down and gives no item on the output.
// Output channel rsp_*: one item per closed frame; tuser is the sensor, tdata bit 0 is
// detected and bit 1 is evaluated. Samples that do not close a frame give no item.
// Configuration port csr_*: index 0 distance threshold, 1 near percent, 2 hold ticks;
// csr_ready is always high and writes are meant for an idle block.
// An item is accepted every cycle unless a frame-closing item waits in the working stage
// for a stalled output. The frame counters sit in a memory with a registered read; an
// item reads its sensor's entry when accepted and writes it back from the working stage
// once that stage advances, with a bypass when consecutive items address the same sensor.
// A result is registered in the output register as its item leaves the working stage.
// Reset clears all counters, flags and holds and loads the register defaults; no clearing
// pass is needed. When the receiver stalls, the output register holds its item and one
// more item may sit in the working stage; a frame-closing item there stops req_tready.
// Depends on tovh_pkg, tovh_frame_mem and tovh_hold_bank.
`default_nettype none
module tof_obstacle_vote_with_hold
   import tovh_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [RANGE_W-1:0]    req_tdata,   // range_mm
   input  wire logic [3:0]            req_tuser,   // op, sensor[1:0], available
   input  wire logic                  req_tlast,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [7:0]                 rsp_tdata,   // detected, evaluated, zero fill
   output logic [SENSOR_W-1:0]        rsp_tuser,   // sensor_out
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   logic [RANGE_W-1:0] thresh_ff;
   logic [PCT_W-1:0]   pct_ff;
   logic [HOLD_W-1:0]  hold_ticks_ff;

   logic                s1_valid_ff;
   logic                s1_op_ff;
   logic [SENSOR_W-1:0] s1_sensor_ff;
   logic                s1_avail_ff;
   logic [RANGE_W-1:0]  s1_range_ff;
   logic                s1_last_ff;

   logic      fwd_valid_ff;
   entry_type fwd_data_ff;

   logic                rsp_valid_ff;
   logic                rsp_det_ff;
   logic                rsp_eval_ff;
   logic [SENSOR_W-1:0] rsp_sensor_ff;

   logic                req_accept;
   logic                s1_adv;
   logic                s1_result;
   logic                s1_in_range;
   entry_type           rd_data;
   entry_type           cur;
   entry_type           wr_data;
   logic                wr_en;
   logic [HOLD_W-1:0]   hold_left;
   hold_cmd_type        hold_cmd;
   logic [PCT_W-1:0]    pct_eff;
   logic [COUNT_W-1:0]  samples_cnt;
   logic [COUNT_W-1:0]  nears_cnt;
   logic [PROD_W-1:0]   near_prod;
   logic [PROD_W-1:0]   need_prod;
   logic                new_det;
   logic                judged;

   function automatic logic wr_data_addr_match(input logic [SENSOR_W-1:0] addr);
      return addr == s1_sensor_ff;
   endfunction

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff     <= '0;
         pct_ff        <= PCT_W'(80);
         hold_ticks_ff <= HOLD_W'(1000);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_DISTANCE_THRESHOLD: thresh_ff     <= csr_data[RANGE_W-1:0];
            CSR_NEAR_PERCENT:       pct_ff        <= csr_data[PCT_W-1:0];
            CSR_HOLD_TICKS:         hold_ticks_ff <= csr_data[HOLD_W-1:0];
            default: ;
         endcase
      end
   end

   assign s1_in_range = {1'b0, s1_sensor_ff} < (SENSOR_W + 1)'(SENSORS);
   assign s1_result   = s1_valid_ff && s1_op_ff == OP_SAMPLE && s1_in_range && s1_last_ff;
   assign s1_adv      = !(s1_result && rsp_valid_ff && !rsp_tready);
   assign req_tready  = !s1_valid_ff || s1_adv;
   assign req_accept  = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_op_ff     <= req_tuser[0];
         s1_sensor_ff <= req_tuser[2:1];
         s1_avail_ff  <= req_tuser[3];
         s1_range_ff  <= req_tdata;
         s1_last_ff   <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else if (req_accept) begin
         fwd_valid_ff <= wr_en && wr_data_addr_match(req_tuser[2:1]);
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         fwd_data_ff <= wr_data;
      end
   end

   tovh_frame_mem u_frame_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_accept),
      .rd_addr (req_tuser[2:1]),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (s1_sensor_ff),
      .wr_data (wr_data)
   );

   tovh_hold_bank u_hold_bank (
      .clock     (clock),
      .reset     (reset),
      .cmd       (hold_cmd),
      .sel       (s1_sensor_ff),
      .hold_left (hold_left)
   );

   always_comb begin
      cur     = fwd_valid_ff ? fwd_data_ff : rd_data;
      pct_eff = (pct_ff > PCT_FULL) ? PCT_FULL : pct_ff;

      samples_cnt = cur.samples;
      nears_cnt   = cur.nears;
      if (cur.samples < COUNT_W'(MAX_POINTS)) begin
         samples_cnt = cur.samples + COUNT_W'(1);
         if (s1_range_ff < thresh_ff) begin
            nears_cnt = cur.nears + COUNT_W'(1);
         end
      end

      near_prod = PROD_W'(nears_cnt) * PROD_W'(PCT_FULL);
      need_prod = PROD_W'(pct_eff) * PROD_W'(samples_cnt);

      hold_cmd        = '0;
      hold_cmd.sensor = s1_sensor_ff;
      hold_cmd.value  = hold_ticks_ff;
      hold_cmd.tick   = s1_valid_ff && s1_op_ff == OP_TICK;

      judged  = 1'b1;
      new_det = cur.det;
      if (!s1_avail_ff) begin
         new_det        = 1'b0;
         hold_cmd.clear = s1_result && s1_adv;
      end else if (cur.det && hold_left != '0) begin
         judged = 1'b0;
      end else if (near_prod >= need_prod) begin
         new_det       = 1'b1;
         hold_cmd.load = s1_result && s1_adv;
      end else begin
         new_det        = 1'b0;
         hold_cmd.clear = s1_result && s1_adv;
      end

      wr_en = s1_valid_ff && s1_op_ff == OP_SAMPLE && s1_in_range && s1_adv;
      if (s1_last_ff) begin
         wr_data.det     = new_det;
         wr_data.samples = '0;
         wr_data.nears   = '0;
      end else begin
         wr_data.det     = cur.det;
         wr_data.samples = samples_cnt;
         wr_data.nears   = nears_cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_result && s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_result && s1_adv) begin
         rsp_det_ff    <= new_det;
         rsp_eval_ff   <= judged;
         rsp_sensor_ff <= s1_sensor_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_sensor_ff;
   assign rsp_tdata  = {6'b0, rsp_eval_ff, rsp_det_ff};

   a_skipped_is_detected: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_eval_ff |-> rsp_det_ff)
      else $error("skipped frame reported without detection");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> wr_data.samples <= COUNT_W'(MAX_POINTS) && wr_data.nears <= wr_data.samples)
      else $error("frame counters out of bounds");

   a_stall_keeps_stage: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff && $stable(s1_sensor_ff))
      else $error("working stage lost its item under stall");

   a_no_write_on_stall: assert property (@(posedge clock) disable iff (reset)
      !s1_adv |-> !wr_en && !hold_cmd.load && !hold_cmd.clear)
      else $error("state written while stalled");

endmodule
`default_nettype wire

/* sim/tof_obstacle_vote_with_hold_tb.sv */
// Testbench for the per-sensor obstacle vote with hold: directed frames, then random phases.
// A scoreboard class predicts each frame verdict and checks rsp items in order.
// Depends on tovh_pkg and the tof_obstacle_vote_with_hold top level.
module tof_obstacle_vote_with_hold_tb;
   import tovh_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 6;
   localparam int PHASES       = 10;
   localparam int PHASE_ITEMS  = 108;

   typedef struct packed {
      logic                op;
      logic [SENSOR_W-1:0] sensor;
      logic                avail;
      logic [RANGE_W-1:0]  range_mm;
      logic                last;
   } ranging_item_type;

   typedef struct packed {
      logic [SENSOR_W-1:0] sensor;
      logic                detected;
      logic                evaluated;
   } verdict_type;

   class vote_scoreboard;
      logic [RANGE_W-1:0]  dist_thr;
      logic [PCT_W-1:0]    near_pct;
      logic [HOLD_W-1:0]   hold_len;
      logic [COUNT_W-1:0]  near_count[SENSORS];
      logic [COUNT_W-1:0]  sample_count[SENSORS];
      logic                det_flag[SENSORS];
      logic [HOLD_W-1:0]   hold_left[SENSORS];
      verdict_type         verdicts[$];
      int errors, checked, ticks, judged, held, unavail, detections, overflow_samples;

      function new();
         dist_thr = '0;
         near_pct = PCT_W'(80);
         hold_len = HOLD_W'(1000);
         for (int s = 0; s < SENSORS; s++) begin
            near_count[s] = '0;
            sample_count[s] = '0;
            det_flag[s] = 1'b0;
            hold_left[s] = '0;
         end
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_DISTANCE_THRESHOLD: dist_thr = data[RANGE_W-1:0];
            CSR_NEAR_PERCENT:       near_pct = data[PCT_W-1:0];
            CSR_HOLD_TICKS:         hold_len = data[HOLD_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_input(ranging_item_type it);
         int s;
         int pct;
         verdict_type v;
         if (it.op == OP_TICK) begin
            ticks++;
            for (int i = 0; i < SENSORS; i++)
               if (hold_left[i] != 0) hold_left[i] = hold_left[i] - HOLD_W'(1);
            return;
         end
         s = int'(it.sensor);
         if (s >= SENSORS) return;
         if (sample_count[s] < MAX_POINTS) begin
            sample_count[s]++;
            if (it.range_mm < dist_thr) near_count[s]++;
         end else begin
            overflow_samples++;
         end
         if (!it.last) return;
         pct = (near_pct > PCT_FULL) ? 100 : int'(near_pct);
         v.sensor = it.sensor;
         v.evaluated = 1'b1;
         if (!it.avail) begin
            det_flag[s] = 1'b0;
            hold_left[s] = '0;
            unavail++;
         end else if (det_flag[s] && hold_left[s] != 0) begin
            v.evaluated = 1'b0;
            held++;
         end else if (int'(near_count[s]) * 100 >= pct * int'(sample_count[s])) begin
            det_flag[s] = 1'b1;
            hold_left[s] = hold_len;
            judged++;
            detections++;
         end else begin
            det_flag[s] = 1'b0;
            hold_left[s] = '0;
            judged++;
         end
         near_count[s] = '0;
         sample_count[s] = '0;
         v.detected = det_flag[s];
         verdicts.push_back(v);
      endfunction

      task report(string msg);
         if (errors < 40) $display("mismatch: %s", msg);
         errors++;
      endtask

      task check_result(logic [SENSOR_W-1:0] sensor, logic [7:0] data);
         verdict_type e;
         if (verdicts.size() == 0) begin
            report($sformatf("unexpected item sensor %0d data %h", sensor, data));
            return;
         end
         e = verdicts.pop_front();
         checked++;
         if (sensor !== e.sensor)
            report($sformatf("sensor %0d, expected %0d", sensor, e.sensor));
         if (data[0] !== e.detected)
            report($sformatf("detected %b, expected %b (sensor %0d)", data[0], e.detected,
                             e.sensor));
         if (data[1] !== e.evaluated)
            report($sformatf("evaluated %b, expected %b (sensor %0d)", data[1], e.evaluated,
                             e.sensor));
         if (data[7:2] !== 6'd0)
            report($sformatf("fill bits %b not zero", data[7:2]));
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [RANGE_W-1:0]    req_tdata;   // range_mm
   logic [3:0]            req_tuser;   // op, sensor[1:0], available
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [7:0]            rsp_tdata;   // detected, evaluated, zero fill
   logic [SENSOR_W-1:0]   rsp_tuser;   // sensor_out
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   vote_scoreboard sb = new();
   int items_sent;
   int settings_used;
   int holdoff_requests;

   tof_obstacle_vote_with_hold dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles, %0d verdicts outstanding", CYCLE_LIMIT,
               sb.verdicts.size());
      $display("status: fail");
      $finish;
   end

   // Receiver: checks items at the rising edge and changes its stall pattern at the falling one.
   initial begin
      int mode;
      int mode_left;
      int holdoff_left;
      int holdoff_seen;
      int pos;
      logic [7:0] mask;
      mode = 0;
      mode_left = 0;
      holdoff_left = 0;
      holdoff_seen = 0;
      pos = 0;
      mask = 8'hFF;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tuser, rsp_tdata);
         if (holdoff_requests != holdoff_seen) begin
            holdoff_seen = holdoff_requests;
            holdoff_left = 300;
         end
         @(negedge clock);
         pos++;
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_tready = 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(0, 3);
               mode_left = $urandom_range(20, 200);
               mask = 8'($urandom_range(1, 255));
            end
            mode_left--;
            case (mode)
               0: rsp_tready = 1'b1;
               1: rsp_tready = 1'($urandom_range(0, 1));
               2: rsp_tready = ($urandom_range(0, 7) != 0);
               default: rsp_tready = mask[pos % 8];
            endcase
         end
      end
   end

   task automatic put_item(input ranging_item_type it);
      req_tvalid = 1'b1;
      req_tdata = it.range_mm;
      req_tuser = {it.avail, it.sensor, it.op};
      req_tlast = it.last;
      do @(posedge clock); while (!req_tready);
      sb.note_input(it);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic idle_cycles(input int n);
      req_tvalid = 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic sample(input int s, input int range_mm, input bit avail, input bit last);
      ranging_item_type it;
      it.op = OP_SAMPLE;
      it.sensor = SENSOR_W'(s);
      it.avail = avail;
      it.range_mm = RANGE_W'(range_mm);
      it.last = last;
      put_item(it);
   endtask

   task automatic tick(input logic [19:0] noise);
      ranging_item_type it;
      it.op = OP_TICK;
      {it.sensor, it.avail, it.range_mm, it.last} = noise;
      put_item(it);
   endtask

   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (sb.verdicts.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
      @(negedge clock);
   endtask

   task automatic set_config(input int thr, input int pct, input int hold_len);
      wait_drained();
      write_csr(CSR_DISTANCE_THRESHOLD, CSR_DATA_W'(thr));
      write_csr(CSR_NEAR_PERCENT, {9'($urandom_range(0, 511)), pct[PCT_W-1:0]});
      write_csr(CSR_HOLD_TICKS, CSR_DATA_W'(hold_len));
      csr_valid = 1'b0;
      settings_used++;
   endtask

   function automatic int pick_range();
      int v;
      case ($urandom_range(0, 9))
         0: v = 0;
         1: v = 65535;
         2, 3, 4, 5: v = int'(sb.dist_thr) + int'($urandom_range(0, 3)) - 2;
         default: v = $urandom_range(0, 65535);
      endcase
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return v;
   endfunction

   task automatic long_frame(input int s, input int len);
      for (int i = 0; i < len; i++)
         sample(s, pick_range(), $urandom_range(0, 4) != 0, i == len - 1);
   endtask

   task automatic random_phase(input int ph, input int n);
      int count;
      int burst_left;
      int r;
      int s;
      int len;
      bit last;
      bit no_gaps;
      count = 0;
      burst_left = 0;
      no_gaps = ($urandom_range(0, 3) == 0);
      if (ph % 3 == 0) begin
         len = $urandom_range(62, 70);
         long_frame($urandom_range(0, SENSORS - 1), len);
         count += len;
      end
      while (count < n) begin
         if (!no_gaps) begin
            if (burst_left == 0) begin
               idle_cycles($urandom_range(1, 6));
               burst_left = $urandom_range(1, 16);
            end
            burst_left--;
         end
         if (ph == 2 && count == n / 2) begin
            holdoff_requests++;
            for (int i = 0; i < 30; i++)
               sample($urandom_range(0, SENSORS - 1), pick_range(), 1'b1, 1'b1);
            count += 30;
         end
         if (ph == 4 && count == n / 2) wait_drained();
         r = $urandom_range(0, 99);
         if (r < 12) begin
            tick(20'($urandom));
         end else begin
            s = $urandom_range(0, SENSORS - 1);
            last = ($urandom_range(0, 3) == 0);
            sample(s, pick_range(),
                   last ? ($urandom_range(0, 4) != 0) : 1'($urandom_range(0, 1)), last);
         end
         count++;
      end
   endtask

   initial begin
      int thr;
      int pct;
      int hold_len;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      req_tlast = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      items_sent = 0;
      settings_used = 0;
      holdoff_requests = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Register defaults straight out of reset.
      sample(3, 0, 1'b1, 1'b1);
      tick(20'hFFFFF);

      set_config(1000, 50, 2);
      sample(0, 0, 1'b1, 1'b1);
      sample(0, 65535, 1'b1, 1'b1);
      tick(20'hFFFFF);
      sample(0, 65535, 1'b1, 1'b1);
      tick(20'h00000);
      sample(0, 65535, 1'b1, 1'b1);
      sample(1, 999, 1'b0, 1'b0);
      sample(1, 1000, 1'b1, 1'b1);
      sample(1, 0, 1'b0, 1'b1);
      sample(2, 0, 1'b1, 1'b1);
      sample(2, 0, 1'b0, 1'b0);
      sample(2, 0, 1'b0, 1'b1);
      sample(3, 0, 1'b0, 1'b0);
      sample(2, 65535, 1'b1, 1'b1);
      sample(3, 65535, 1'b1, 1'b1);
      sample(3, 1, 1'b1, 1'b1);
      tick(20'h5A5A5);
      sample(3, 999, 1'b1, 1'b1);

      for (int ph = 0; ph < PHASES; ph++) begin
         thr = $urandom_range(0, 65535);
         pct = $urandom_range(1, 100);
         hold_len = $urandom_range(0, 8);
         case (ph)
            0: begin thr = 1000; pct = 50; hold_len = 2; end
            1: begin thr = 0; pct = 1; hold_len = 0; end
            2: begin thr = 65535; pct = 100; hold_len = 65535; end
            3: begin pct = 0; hold_len = 3; end
            4: begin pct = 127; hold_len = 1; end
            6: begin thr = 300; pct = 80; hold_len = 0; end
            9: hold_len = 5;
            default: ;
         endcase
         set_config(thr, pct, hold_len);
         if (ph == 5) begin
            write_csr(2'd3, CSR_DATA_W'($urandom_range(0, 65535)));
            csr_valid = 1'b0;
         end
         random_phase(ph, PHASE_ITEMS);
      end

      wait_drained();
      $display("covered %0d items over %0d register settings: %0d verdicts checked, %0d ticks",
               items_sent, settings_used, sb.checked, sb.ticks);
      $display("frames judged %0d (detections %0d), held %0d, unavailable %0d, overflow %0d",
               sb.judged, sb.detections, sb.held, sb.unavail, sb.overflow_samples);
      if (sb.errors == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("status: fail");
      end
      $finish;
   end
endmodule

/* filelist.f */
rtl/tovh_pkg.sv
rtl/tovh_frame_mem.sv
rtl/tovh_hold_bank.sv
rtl/tof_obstacle_vote_with_hold.sv
sim/tof_obstacle_vote_with_hold_tb.sv
